FILE: rtl/core/best_fit_heap_allocator_assert.svh
// Assertion macros for the best-fit heap allocator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BFHA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfha: assertion failed");
// next-cycle implication
`define BFHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfha: assertion failed");
`else
`define BFHA_ASSERT_NOW(label, ante, cons)
`define BFHA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and codes of the best-fit heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfha_pkg;

  localparam int SIZE_W         = 17;   // chunk size / heap size in bytes
  localparam int POS_W          = 18;   // byte position, holds pos + size
  localparam int CNT_W          = 12;
  localparam int OFF_W          = 16;
  localparam int HEAP_FLOOR     = 4096;
  localparam int HEAP_MAX_BYTES = 65536; // bounded by the 16-bit offsets
  localparam int HEADER_SIZE    = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_ALLOC = 2'd1;
  localparam logic [1:0] MARK_FREE  = 2'd2;

  typedef struct packed {
    logic [1:0]        mark;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfha_heap_cfg.sv
// ----------------------------------------------------------------------------
// bfha_heap_cfg
// Heap size register: clamps and rounds written values, requests a reformat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfha_heap_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [bfha_pkg::SIZE_W-1:0]     wr_data,
  output logic      [bfha_pkg::SIZE_W-1:0]     heap_bytes,
  output logic                                 fmt
);

  localparam logic [bfha_pkg::POS_W-1:0] HMAX  = bfha_pkg::POS_W'(bfha_pkg::HEAP_MAX_BYTES);
  localparam logic [bfha_pkg::POS_W-1:0] FLOOR = bfha_pkg::POS_W'(bfha_pkg::HEAP_FLOOR);

  logic [bfha_pkg::POS_W-1:0] v_floor;
  logic [bfha_pkg::POS_W-1:0] v_round;
  logic [bfha_pkg::POS_W-1:0] v_clamp;

  always_comb begin
    v_floor = {1'b0, wr_data};
    if (v_floor < FLOOR) begin
      v_floor = FLOOR;
    end
    v_round = (v_floor + bfha_pkg::POS_W'(3)) & ~bfha_pkg::POS_W'(3);
    v_clamp = (v_round > HMAX) ? HMAX : v_round;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes <= HMAX[bfha_pkg::SIZE_W-1:0];
      fmt        <= 1'b1;
    end else begin
      fmt <= wr_en;
      if (wr_en) begin
        heap_bytes <= v_clamp[bfha_pkg::SIZE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit allocator over a chunk-header store, with split and coalescing.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | op, req_bytes, data_offset
// out     | out | out_valid/out_stall| status, alloc_offset, free_chunks
// cfg     | in  | cfg_valid/cfg_ready| cfg_data (heap_bytes)
//
// An allocate walks every chunk header; a free walks the headers up to the
// freed chunk, then walks the whole heap again to merge free neighbors. Each
// header visited costs one read of the single-port-read header memory.
// Reset and a heap size write format the heap by writing header 0 only.
// The result register lets a new request start while a result is stalled.
// A pending cfg write holds off new requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module best_fit_heap_allocator #(
  parameter int MIN_FREE_CHUNK = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          op,
  input  wire logic [bfha_pkg::SIZE_W-1:0]   req_bytes,
  input  wire logic [bfha_pkg::OFF_W-1:0]    data_offset,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [1:0]                    status,
  output logic      [bfha_pkg::OFF_W-1:0]    alloc_offset,
  output logic      [bfha_pkg::CNT_W-1:0]    free_chunks,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfha_pkg::SIZE_W-1:0]   cfg_data
);

`include "best_fit_heap_allocator_assert.svh"

  localparam int UNITS = bfha_pkg::HEAP_MAX_BYTES / 4;
  localparam int AW    = $clog2(UNITS);
  localparam int PW    = bfha_pkg::POS_W;
  localparam int SW    = bfha_pkg::SIZE_W;
  localparam logic [PW-1:0] SPLIT_MIN = PW'(bfha_pkg::HEADER_SIZE + MIN_FREE_CHUNK);
  localparam logic [PW-1:0] HDR       = PW'(bfha_pkg::HEADER_SIZE);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_AWALK = 4'd2;
  localparam logic [3:0] S_AWR1  = 4'd3;
  localparam logic [3:0] S_AWR2  = 4'd4;
  localparam logic [3:0] S_FWALK = 4'd5;
  localparam logic [3:0] S_FMARK = 4'd6;
  localparam logic [3:0] S_CSTRT = 4'd7;
  localparam logic [3:0] S_CHEAD = 4'd8;
  localparam logic [3:0] S_CNEXT = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // header store
  bfha_pkg::entry_t mem [UNITS];
  bfha_pkg::entry_t rdata;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wr_addr;
  bfha_pkg::entry_t wr_data;

  logic [SW-1:0] heap_bytes;
  logic          fmt;

  logic [3:0]                  state, state_next;
  logic                        cur_op, cur_op_next;
  logic [PW-1:0]               pos, pos_next;
  logic [SW-1:0]               cur_s, cur_s_next;
  logic [PW-1:0]               best, best_next;
  logic [SW-1:0]               best_size, best_size_next;
  logic                        found, found_next;
  logic [PW-1:0]               need, need_next;
  logic [PW-1:0]               hpos, hpos_next;
  logic [bfha_pkg::CNT_W-1:0]  free_cnt, free_cnt_next;
  logic [1:0]                  res_status, res_status_next;
  logic [bfha_pkg::OFF_W-1:0]  res_offset, res_offset_next;

  logic          in_acc;
  logic          walk_end;
  logic [PW-1:0] heap_ext;
  logic [PW-1:0] pos_adv;
  logic [PW-1:0] rem;
  logic [PW-1:0] nxt;
  logic [SW-1:0] sum;
  logic [PW-1:0] after_sum;
  logic [PW-1:0] split_pos;
  logic          merge_hit;

  bfha_heap_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_data   (cfg_data),
    .heap_bytes(heap_bytes),
    .fmt       (fmt)
  );

  assign cfg_ready = (state == S_IDLE) && !fmt;
  assign in_stall  = (state != S_IDLE) || fmt || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign merge_hit = (state == S_CNEXT) && (rdata.mark == bfha_pkg::MARK_FREE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    heap_ext  = {1'b0, heap_bytes};
    walk_end  = (pos >= heap_ext) || (rdata.size < SW'(4));
    pos_adv   = pos + {1'b0, rdata.size};
    rem       = {1'b0, best_size} - need;
    nxt       = pos + {1'b0, cur_s};
    sum       = cur_s + rdata.size;
    after_sum = pos + {1'b0, sum};
    split_pos = best + need;
  end

  always_comb begin
    state_next      = state;
    cur_op_next     = cur_op;
    pos_next        = pos;
    cur_s_next      = cur_s;
    best_next       = best;
    best_size_next  = best_size;
    found_next      = found;
    need_next       = need;
    hpos_next       = hpos;
    free_cnt_next   = free_cnt;
    res_status_next = res_status;
    res_offset_next = res_offset;
    rd_en           = 1'b0;
    rd_addr         = '0;
    we              = 1'b0;
    wr_addr         = '0;
    wr_data         = '{mark: bfha_pkg::MARK_FREE, size: heap_bytes};

    case (state)
      S_IDLE: begin
        if (fmt) begin
          we            = 1'b1;
          free_cnt_next = bfha_pkg::CNT_W'(1);
        end else if (in_acc) begin
          cur_op_next     = op;
          res_offset_next = '0;
          res_status_next = bfha_pkg::ST_OK;
          if (op == bfha_pkg::OP_ALLOC) begin
            need_next      = (({1'b0, req_bytes} + PW'(3)) & ~PW'(3)) + HDR;
            best_size_next = heap_bytes;
            found_next     = 1'b0;
            if (req_bytes == '0) begin
              res_status_next = bfha_pkg::ST_BAD_SIZE;
              state_next      = S_DONE;
            end else begin
              state_next = S_START;
            end
          end else begin
            hpos_next = {2'b00, data_offset} - HDR;
            if (data_offset < bfha_pkg::OFF_W'(bfha_pkg::HEADER_SIZE) ||
                data_offset[1:0] != 2'b00) begin
              res_status_next = bfha_pkg::ST_BAD_FREE;
              state_next      = S_DONE;
            end else begin
              state_next = S_START;
            end
          end
        end
      end
      S_START: begin
        rd_en      = 1'b1;
        pos_next   = '0;
        state_next = (cur_op == bfha_pkg::OP_ALLOC) ? S_AWALK : S_FWALK;
      end
      S_AWALK: begin
        if (walk_end) begin
          if (found) begin
            state_next = S_AWR1;
          end else begin
            res_status_next = bfha_pkg::ST_NO_SPACE;
            state_next      = S_DONE;
          end
        end else begin
          if (rdata.mark == bfha_pkg::MARK_FREE && need <= {1'b0, rdata.size} &&
              rdata.size <= best_size) begin
            best_next      = pos;
            best_size_next = rdata.size;
            found_next     = 1'b1;
          end
          pos_next = pos_adv;
          rd_en    = 1'b1;
          rd_addr  = pos_adv[AW+1:2];
        end
      end
      S_AWR1: begin
        we              = 1'b1;
        wr_addr         = best[AW+1:2];
        res_offset_next = bfha_pkg::OFF_W'(best + HDR);
        if (rem >= SPLIT_MIN) begin
          wr_data    = '{mark: bfha_pkg::MARK_ALLOC, size: need[SW-1:0]};
          state_next = S_AWR2;
        end else begin
          wr_data       = '{mark: bfha_pkg::MARK_ALLOC, size: best_size};
          free_cnt_next = free_cnt - bfha_pkg::CNT_W'(1);
          state_next    = S_DONE;
        end
      end
      S_AWR2: begin
        // remainder becomes a free chunk right after the new one
        we         = 1'b1;
        wr_addr    = split_pos[AW+1:2];
        wr_data    = '{mark: bfha_pkg::MARK_FREE, size: rem[SW-1:0]};
        state_next = S_DONE;
      end
      S_FWALK: begin
        if (walk_end || pos > hpos) begin
          res_status_next = bfha_pkg::ST_BAD_FREE;
          state_next      = S_DONE;
        end else if (pos == hpos) begin
          if (rdata.mark == bfha_pkg::MARK_ALLOC) begin
            cur_s_next = rdata.size;
            state_next = S_FMARK;
          end else begin
            res_status_next = bfha_pkg::ST_BAD_FREE;
            state_next      = S_DONE;
          end
        end else begin
          pos_next = pos_adv;
          rd_en    = 1'b1;
          rd_addr  = pos_adv[AW+1:2];
        end
      end
      S_FMARK: begin
        we            = 1'b1;
        wr_addr       = hpos[AW+1:2];
        wr_data       = '{mark: bfha_pkg::MARK_FREE, size: cur_s};
        free_cnt_next = free_cnt + bfha_pkg::CNT_W'(1);
        state_next    = S_CSTRT;
      end
      S_CSTRT: begin
        // separate cycle so the read of header 0 sees the mark just written
        rd_en      = 1'b1;
        pos_next   = '0;
        state_next = S_CHEAD;
      end
      S_CHEAD: begin
        if (walk_end) begin
          state_next = S_DONE;
        end else begin
          cur_s_next = rdata.size;
          rd_en      = 1'b1;
          rd_addr    = pos_adv[AW+1:2];
          if (pos_adv < heap_ext && rdata.mark == bfha_pkg::MARK_FREE) begin
            state_next = S_CNEXT;
          end else begin
            pos_next = pos_adv;
          end
        end
      end
      S_CNEXT: begin
        // rdata is the header that follows the free chunk at pos
        if (rdata.mark == bfha_pkg::MARK_FREE) begin
          we            = 1'b1;
          wr_addr       = pos[AW+1:2];
          wr_data       = '{mark: bfha_pkg::MARK_FREE, size: sum};
          cur_s_next    = sum;
          free_cnt_next = free_cnt - bfha_pkg::CNT_W'(1);
          if (after_sum < heap_ext) begin
            rd_en   = 1'b1;
            rd_addr = after_sum[AW+1:2];
          end else begin
            state_next = S_DONE;
          end
        end else begin
          pos_next   = nxt;
          rd_en      = 1'b1;
          rd_addr    = nxt[AW+1:2];
          state_next = S_CHEAD;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_cnt  <= bfha_pkg::CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      free_cnt <= free_cnt_next;
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_op     <= cur_op_next;
    pos        <= pos_next;
    cur_s      <= cur_s_next;
    best       <= best_next;
    best_size  <= best_size_next;
    found      <= found_next;
    need       <= need_next;
    hpos       <= hpos_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status       <= res_status;
      alloc_offset <= res_offset;
      free_chunks  <= free_cnt;
    end
  end

  `BFHA_ASSERT_NOW(a_fail_no_offset, out_valid && status != bfha_pkg::ST_OK, alloc_offset == '0)
  `BFHA_ASSERT_NOW(a_no_rw_clash, we && rd_en, wr_addr != rd_addr)
  `BFHA_ASSERT_NEXT(a_merge_count, merge_hit, free_cnt == $past(free_cnt) - bfha_pkg::CNT_W'(1))

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the best-fit heap allocator. A local model of the chunk store
// predicts every response (status, payload offset, free chunk count) and a
// checker compares each response against the oldest prediction. Directed tests
// cover bad requests, exact fit, split threshold, tie-break and merging;
// random traffic runs at several heap sizes with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HEAP_MAX = bfha_pkg::HEAP_MAX_BYTES;
  localparam int MIN_FREE = 32;
  localparam int UNITS    = HEAP_MAX / 4;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          op = bfha_pkg::OP_ALLOC;
  logic [bfha_pkg::SIZE_W-1:0]   req_bytes = '0;
  logic [bfha_pkg::OFF_W-1:0]    data_offset = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [bfha_pkg::SIZE_W-1:0]   cfg_data = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic [1:0]                    status;
  logic [bfha_pkg::OFF_W-1:0]    alloc_offset;
  logic [bfha_pkg::CNT_W-1:0]    free_chunks;
  logic                          cfg_ready;

  best_fit_heap_allocator #(
    .MIN_FREE_CHUNK(MIN_FREE)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .req_bytes(req_bytes), .data_offset(data_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .alloc_offset(alloc_offset), .free_chunks(free_chunks),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [1:0]                 st;
    logic [bfha_pkg::OFF_W-1:0] off;
    logic [bfha_pkg::CNT_W-1:0] cnt;
  } resp_t;

  resp_t       resp_q[$];
  resp_t       exp_r;
  int unsigned live_q[$];

  // heap model
  logic [1:0]  mark_m[UNITS];
  int unsigned size_m[UNITS];
  int unsigned heap_sz;

  int errors = 0;
  int n_reqs = 0;
  int n_resps = 0;
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  int stall_left = 0;

  function void format_heap();
    foreach (mark_m[i]) begin
      mark_m[i] = bfha_pkg::MARK_NONE;
      size_m[i] = 0;
    end
    mark_m[0] = bfha_pkg::MARK_FREE;
    size_m[0] = heap_sz;
  endfunction

  function int unsigned count_free();
    int unsigned pos, n;
    pos = 0;
    n = 0;
    while (pos < heap_sz) begin
      if (size_m[pos>>2] < 4) break;
      if (mark_m[pos>>2] == bfha_pkg::MARK_FREE) n++;
      pos += size_m[pos>>2];
    end
    return n;
  endfunction

  function logic [1:0] heap_alloc(int unsigned req, output int unsigned off);
    int unsigned need, pos, best, best_sz, s, rem;
    bit found;
    off = 0;
    if (req == 0) return bfha_pkg::ST_BAD_SIZE;
    need = ((req + 3) & ~32'd3) + bfha_pkg::HEADER_SIZE;
    pos = 0;
    best = 0;
    best_sz = heap_sz;
    found = 0;
    while (pos < heap_sz) begin
      s = size_m[pos>>2];
      if (s < 4) break;
      // <= keeps the highest address among equal sizes
      if (mark_m[pos>>2] == bfha_pkg::MARK_FREE && need <= s && s <= best_sz) begin
        best = pos;
        best_sz = s;
        found = 1;
      end
      pos += s;
    end
    if (!found) return bfha_pkg::ST_NO_SPACE;
    mark_m[best>>2] = bfha_pkg::MARK_ALLOC;
    rem = best_sz - need;
    if (rem >= bfha_pkg::HEADER_SIZE + MIN_FREE) begin
      size_m[best>>2] = need;
      mark_m[(best+need)>>2] = bfha_pkg::MARK_FREE;
      size_m[(best+need)>>2] = rem;
    end
    off = best + bfha_pkg::HEADER_SIZE;
    return bfha_pkg::ST_OK;
  endfunction

  function logic [1:0] heap_free(int unsigned d);
    int unsigned h, pos, s, nxt;
    bit hit;
    if (d < bfha_pkg::HEADER_SIZE || (d & 3) != 0) return bfha_pkg::ST_BAD_FREE;
    h = d - bfha_pkg::HEADER_SIZE;
    pos = 0;
    hit = 0;
    while (pos < heap_sz) begin
      s = size_m[pos>>2];
      if (s < 4) break;
      if (pos == h) begin
        hit = (mark_m[pos>>2] == bfha_pkg::MARK_ALLOC);
        break;
      end
      if (pos > h) break;
      pos += s;
    end
    if (!hit) return bfha_pkg::ST_BAD_FREE;
    mark_m[h>>2] = bfha_pkg::MARK_FREE;
    pos = 0;
    while (pos < heap_sz) begin
      s = size_m[pos>>2];
      if (s < 4) break;
      nxt = pos + s;
      if (nxt < heap_sz && mark_m[pos>>2] == bfha_pkg::MARK_FREE &&
          mark_m[nxt>>2] == bfha_pkg::MARK_FREE) begin
        size_m[pos>>2] = s + size_m[nxt>>2];
        mark_m[nxt>>2] = bfha_pkg::MARK_NONE;
        size_m[nxt>>2] = 0;
        continue;
      end
      pos = nxt;
    end
    return bfha_pkg::ST_OK;
  endfunction

  // one request; the unused field carries random bits
  task automatic send_req(input logic o, input int unsigned rb, input int unsigned off);
    resp_t       r;
    int          gap;
    int unsigned ao;
    int          idx[$];
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (o == bfha_pkg::OP_FREE) rb = $urandom_range(0, 131071);
    else off = $urandom_range(0, 65535);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    req_bytes <= rb[bfha_pkg::SIZE_W-1:0];
    data_offset <= off[bfha_pkg::OFF_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ao = 0;
    if (o == bfha_pkg::OP_ALLOC) begin
      r.st = heap_alloc(rb & 32'h1FFFF, ao);
      if (r.st == bfha_pkg::ST_OK) live_q.push_back(ao);
    end else begin
      r.st = heap_free(off & 32'hFFFF);
      if (r.st == bfha_pkg::ST_OK) begin
        idx = live_q.find_first_index(x) with (x == (off & 32'hFFFF));
        if (idx.size() > 0) live_q.delete(idx[0]);
      end
    end
    r.off = (r.st == bfha_pkg::ST_OK) ? ao[bfha_pkg::OFF_W-1:0] : '0;
    r.cnt = count_free();
    resp_q.push_back(r);
    n_reqs++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_heap(input int unsigned v);
    int unsigned n;
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[bfha_pkg::SIZE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n = v & 32'h1FFFF;
    if (n < bfha_pkg::HEAP_FLOOR) n = bfha_pkg::HEAP_FLOOR;
    n = (n + 3) & ~32'd3;
    if (n > HEAP_MAX) n = HEAP_MAX;
    heap_sz = n;
    format_heap();
    live_q.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: long hold-off first, then a random wait drawn per response
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (resp_q.size() == 0) begin
        errors++;
        $display("%0t: response with none pending, status %0d", $time, status);
      end else begin
        exp_r = resp_q.pop_front();
        if (status !== exp_r.st) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, exp_r.st, status);
        end
        if (alloc_offset !== exp_r.off) begin
          errors++;
          $display("%0t: alloc_offset exp %0d got %0d", $time, exp_r.off, alloc_offset);
        end
        if (free_chunks !== exp_r.cnt) begin
          errors++;
          $display("%0t: free_chunks exp %0d got %0d", $time, exp_r.cnt, free_chunks);
        end
      end
      n_resps++;
      stall_left = gaps_on ? $urandom_range(0, 15) : 0;
    end
  end

  task automatic test_bad_requests();
    send_req(bfha_pkg::OP_ALLOC, 0, 0);
    send_req(bfha_pkg::OP_ALLOC, 65536, 0);
    send_req(bfha_pkg::OP_ALLOC, 65535, 0);
    send_req(bfha_pkg::OP_FREE, 0, 0);
    send_req(bfha_pkg::OP_FREE, 0, 4);
    send_req(bfha_pkg::OP_FREE, 0, 10);
    send_req(bfha_pkg::OP_FREE, 0, 65535);
    send_req(bfha_pkg::OP_FREE, 0, 8);      // chunk at 0 is free
  endtask

  task automatic test_fit_and_split();
    send_req(bfha_pkg::OP_ALLOC, 65528, 0); // exact fit
    send_req(bfha_pkg::OP_ALLOC, 1, 0);
    send_req(bfha_pkg::OP_FREE, 0, 8);
    send_req(bfha_pkg::OP_ALLOC, 65492, 0); // remainder 36, too small to split
    send_req(bfha_pkg::OP_FREE, 0, 8);
    send_req(bfha_pkg::OP_ALLOC, 65488, 0); // remainder 40, split
    send_req(bfha_pkg::OP_FREE, 0, 8);
  endtask

  task automatic test_tie_and_merge();
    int unsigned a[5];
    for (int i = 0; i < 5; i++) begin
      send_req(bfha_pkg::OP_ALLOC, 100, 0);
      a[i] = live_q[live_q.size()-1];
    end
    send_req(bfha_pkg::OP_FREE, 0, a[1]);
    send_req(bfha_pkg::OP_FREE, 0, a[3]);
    send_req(bfha_pkg::OP_ALLOC, 97, 0);    // equal holes: higher one wins
    send_req(bfha_pkg::OP_FREE, 0, a[3]);   // frees the chunk that took the higher hole
    send_req(bfha_pkg::OP_FREE, 0, a[2]);   // merges with both of its neighbors
    send_req(bfha_pkg::OP_FREE, 0, a[0]);
    while (live_q.size() > 0) send_req(bfha_pkg::OP_FREE, 0, live_q[0]);
  endtask

  task automatic test_heap_config();
    set_heap(0);
    send_req(bfha_pkg::OP_ALLOC, 4088, 0);
    send_req(bfha_pkg::OP_ALLOC, 1, 0);
    set_heap(4097);
    send_req(bfha_pkg::OP_ALLOC, 4092, 0);
    send_req(bfha_pkg::OP_FREE, 0, 8);
    set_heap(131071);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    gaps_on = 1'b0;
    repeat (12) send_req(bfha_pkg::OP_ALLOC, $urandom_range(1, 200), 0);
    gaps_on = 1'b1;
    drain();
  endtask

  task automatic test_random(input int n);
    int pick;
    int unsigned sz;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 19))
          0:       sz = 0;
          1:       sz = $urandom_range(heap_sz - 64, 65536);
          2, 3:    sz = $urandom_range(257, heap_sz / 4);
          default: sz = $urandom_range(1, 256);
        endcase
        send_req(bfha_pkg::OP_ALLOC, sz, 0);
      end else if (pick < 88 && live_q.size() > 0) begin
        send_req(bfha_pkg::OP_FREE, 0, live_q[$urandom_range(0, live_q.size() - 1)]);
      end else begin
        send_req(bfha_pkg::OP_FREE, 0, $urandom_range(0, 65535));
      end
    end
  endtask

  initial begin
    #(5_000_000);
    $display("FAIL best_fit_heap_allocator");
    $finish;
  end

  initial begin
    heap_sz = HEAP_MAX;
    format_heap();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_bad_requests();
    test_fit_and_split();
    test_tie_and_merge();
    test_heap_config();
    test_backpressure();
    test_random(45);
    set_heap(4100);
    test_random(25);
    set_heap(20000);
    gaps_on = 1'b0;
    test_random(20);
    gaps_on = 1'b1;
    set_heap(65536);
    test_random(15);
    drain();
    $display("run: %0d requests, %0d responses checked", n_reqs, n_resps);
    $display("heap sizes 4096 to 65536, bad requests, split, ties, merges, stalls");
    if (errors == 0) begin
      $display("PASS best_fit_heap_allocator");
    end else begin
      $display("FAIL best_fit_heap_allocator");
    end
    $finish;
  end

endmodule
